[design/assert_macros.svh]
// assertion macros for the design files
// no dependencies; included by modules that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// implication with a fixed delay in cycles
`define ASSERT_DELAYED(label, clk, rst_n, ante, dly, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
        else $error("delayed implication check failed");

`endif

[design/tlapf_pkg.sv]
// constants, register codes and rounding helpers for the arm pose fit block
// no dependencies; imported by tlapf_div, tlapf_sincos, two_link_arm_pose_fit and its testbench
`default_nettype none

package tlapf_pkg;

    localparam int VIEW_WIDTH  = 640;
    localparam int VIEW_HEIGHT = 480;
    localparam int MIN_SIDE    = 48;
    localparam int VIEW_MIN    = (VIEW_WIDTH < VIEW_HEIGHT) ? VIEW_WIDTH : VIEW_HEIGHT;

    localparam int TURN_UNITS = 46080;
    localparam int SLACK      = 131;

    // quarter-wave sine polynomial, Q30
    localparam logic [30:0] ONE_Q30 = 31'd1073741824;
    localparam logic [30:0] K9 = 31'd172272;
    localparam logic [30:0] SINE_COEF [4] = '{31'd5026995, 31'd85569310,
                                              31'd693598668, 31'd1686629713};

    // angle to phase: phase = x * PH_MUL + floor((34x + 22) / 45)
    localparam int PH_MUL   = 93206;
    localparam int PH_ADJ   = 34;
    localparam int PH_BIAS  = 22;
    localparam int RECIP_45 = 2982617;
    localparam int RECIP_SH = 27;

    localparam int DIV_LAT  = 32;
    localparam int SC_LAT   = 7;
    localparam int W_DLY    = DIV_LAT + 2 * SC_LAT + 7;
    localparam int ANG_DLY  = SC_LAT + 5;
    localparam int PIPE_LAT = 2 * DIV_LAT + 2 * SC_LAT + 10;

    typedef enum logic [2:0] {
        CFG_PERIOD      = 3'd0,
        CFG_LEN1        = 3'd1,
        CFG_LEN2        = 3'd2,
        CFG_RADIUS      = 3'd3,
        CFG_STROKE      = 3'd4,
        CFG_ROOT_SWING  = 3'd5,
        CFG_CHILD_SWING = 3'd6
    } t_cfg_idx;

    // round to nearest, half away from zero, then shift right by s
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                     input int unsigned s);
        logic [63:0] h;
        logic [63:0] m;
        h = 64'd1 << (s - 1);
        if (!v[63]) begin
            m = (unsigned'(v) + h) >> s;
            return $signed(m);
        end else begin
            m = ((64'd0 - unsigned'(v)) + h) >> s;
            return -$signed(m);
        end
    endfunction

    function automatic logic signed [16:0] clamp17(input logic signed [63:0] v);
        if (v > 64'sd65535) begin
            return 17'sd65535;
        end else if (v < -64'sd65536) begin
            return -17'sd65536;
        end else begin
            return 17'(v);
        end
    endfunction

endpackage

`default_nettype wire

[design/tlapf_div.sv]
// pipelined restoring divider, one quotient bit per stage
// depends on tlapf_pkg; divisor must stay steady while a transaction is inside
`default_nettype none

module tlapf_div (
    input  wire logic        i_clk,
    input  wire logic [30:0] i_rem0,
    input  wire logic [31:0] i_low,
    input  wire logic [30:0] i_den,
    output logic      [31:0] o_quo,
    output logic      [30:0] o_rem
);
    import tlapf_pkg::*;

    logic [30:0] r_rem [DIV_LAT];
    logic [31:0] r_low [DIV_LAT];
    logic [31:0] r_quo [DIV_LAT];

    logic [30:0] w_rem_in [DIV_LAT];
    logic [31:0] w_low_in [DIV_LAT];
    logic [31:0] w_quo_in [DIV_LAT];
    logic [31:0] w_trial  [DIV_LAT];
    logic        w_ge     [DIV_LAT];
    logic [30:0] n_rem    [DIV_LAT];

    always_comb begin
        w_rem_in[0] = i_rem0;
        w_low_in[0] = i_low;
        w_quo_in[0] = '0;
        for (int k = 1; k < DIV_LAT; k++) begin
            w_rem_in[k] = r_rem[k-1];
            w_low_in[k] = r_low[k-1];
            w_quo_in[k] = r_quo[k-1];
        end
    end

    always_comb begin
        for (int k = 0; k < DIV_LAT; k++) begin
            w_trial[k] = {w_rem_in[k], w_low_in[k][31]};
            w_ge[k]    = w_trial[k] >= {1'b0, i_den};
            n_rem[k]   = w_ge[k] ? 31'(w_trial[k] - {1'b0, i_den}) : w_trial[k][30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DIV_LAT; k++) begin
            r_rem[k] <= n_rem[k];
            r_low[k] <= {w_low_in[k][30:0], 1'b0};
            r_quo[k] <= {w_quo_in[k][30:0], w_ge[k]};
        end
    end

    assign o_quo = r_quo[DIV_LAT-1];
    assign o_rem = r_rem[DIV_LAT-1];

endmodule

`default_nettype wire

[design/tlapf_sincos.sv]
// pipelined sine and cosine of a 32-bit phase, Q30 results
// depends on tlapf_pkg; two quarter-wave polynomial lanes, seven stages
`default_nettype none

module tlapf_sincos (
    input  wire logic               i_clk,
    input  wire logic        [31:0] i_phase,
    output logic signed      [31:0] o_sin,
    output logic signed      [31:0] o_cos
);
    import tlapf_pkg::*;

    logic [30:0] w_u  [2];
    logic [30:0] r_u  [5][2];
    logic [30:0] r_u2 [4][2];
    logic [61:0] r_m  [5][2];
    logic [1:0]  r_quad [6];
    logic [31:0] w_q  [2];
    logic [30:0] w_a  [2];
    logic [30:0] w_sel_s;
    logic [30:0] w_sel_c;
    logic signed [31:0] r_sin;
    logic signed [31:0] r_cos;

    // lane 0 evaluates the quarter sine at x, lane 1 at one minus x
    assign w_u[0] = {1'b0, i_phase[29:0]};
    assign w_u[1] = ONE_Q30 - {1'b0, i_phase[29:0]};

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_q[l] = 32'(r_m[4][l] >> 30);
            w_a[l] = (w_q[l] > {1'b0, ONE_Q30}) ? ONE_Q30 : w_q[l][30:0];
        end
    end

    assign w_sel_s = r_quad[5][0] ? w_a[1] : w_a[0];
    assign w_sel_c = r_quad[5][0] ? w_a[0] : w_a[1];

    always_ff @(posedge i_clk) begin
        r_quad[0] <= i_phase[31:30];
        for (int i = 1; i < 6; i++) begin
            r_quad[i] <= r_quad[i-1];
        end
        for (int l = 0; l < 2; l++) begin
            r_u[0][l]  <= w_u[l];
            r_u2[0][l] <= 31'((62'(w_u[l]) * 62'(w_u[l])) >> 30);
            for (int i = 1; i < 5; i++) begin
                r_u[i][l] <= r_u[i-1][l];
            end
            for (int i = 1; i < 4; i++) begin
                r_u2[i][l] <= r_u2[i-1][l];
            end
            r_m[0][l] <= 62'(r_u2[0][l]) * 62'(K9);
            // horner steps on u squared
            for (int i = 1; i < 4; i++) begin
                r_m[i][l] <= 62'(r_u2[i][l])
                           * 62'(SINE_COEF[i-1] - 31'(r_m[i-1][l] >> 30));
            end
            // the last step multiplies by u instead of u squared
            r_m[4][l] <= 62'(r_u[4][l]) * 62'(SINE_COEF[3] - 31'(r_m[3][l] >> 30));
        end
        r_sin <= r_quad[5][1] ? -$signed({1'b0, w_sel_s}) : $signed({1'b0, w_sel_s});
        r_cos <= (r_quad[5][1] ^ r_quad[5][0]) ? -$signed({1'b0, w_sel_c})
                                                : $signed({1'b0, w_sel_c});
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

`default_nettype wire

[design/two_link_arm_pose_fit.sv]
// top level: two-link arm pose at a time stamp, fitted to the viewport
// depends on tlapf_pkg, tlapf_div, tlapf_sincos and assert_macros.svh
`default_nettype none

// A transaction starts at any clock edge with start high and busy low, one per
// cycle with no gaps needed; busy is high during reset and for the first cycle
// after it. Each result appears on the o_ ports for exactly one cycle with
// o_done high, in start order, and the receiver cannot hold it off. The path
// runs through two 32-stage dividers (time wrap, then phase), two 7-stage
// sine units (swing angles, then link directions) and eleven register stages
// for input capture, sign fold, wrap fix-up, angle products and rounding, the
// angle-to-phase steps, link products, anchor sums and the output register.
// The fit scale is derived from the configuration by its own 32-stage divider
// and settles, after a register write, well before any transaction started
// after the write needs it.
module two_link_arm_pose_fit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] i_time_us,
    input  wire logic               i_cfg_we,
    input  wire logic        [2:0]  i_cfg_idx,
    input  wire logic        [30:0] i_cfg_data,
    output logic                    o_done,
    output logic                    o_valid_res,
    output logic             [30:0] o_wrapped_time,
    output logic signed      [16:0] o_root_angle,
    output logic signed      [16:0] o_child_angle,
    output logic             [23:0] o_fit_scale,
    output logic signed      [16:0] o_pivot_x,
    output logic signed      [16:0] o_pivot_y,
    output logic signed      [16:0] o_elbow_x,
    output logic signed      [16:0] o_elbow_y,
    output logic signed      [16:0] o_tip_x,
    output logic signed      [16:0] o_tip_y
);
    import tlapf_pkg::*;

`include "assert_macros.svh"

    localparam logic signed [22:0] NUM_BASE = 23'(VIEW_MIN * 256 - 1024);
    localparam logic signed [39:0] PX = 40'(VIEW_WIDTH * 32768);
    localparam logic signed [39:0] PY = 40'(VIEW_HEIGHT * 32768);
    localparam logic signed [41:0] X_HI = 42'(VIEW_WIDTH * 65536 + SLACK);
    localparam logic signed [41:0] Y_HI = 42'(VIEW_HEIGHT * 65536 + SLACK);
    localparam logic signed [41:0] LO_BOUND = -42'(SLACK);
    localparam logic view_small = (VIEW_WIDTH < MIN_SIDE) || (VIEW_HEIGHT < MIN_SIDE);

    // configuration registers
    logic        [30:0] r_period;
    logic        [15:0] r_len1;
    logic        [15:0] r_len2;
    logic        [15:0] r_rad;
    logic        [15:0] r_stroke;
    logic signed [16:0] r_rswing;
    logic signed [16:0] r_cswing;

    logic                r_busy;
    logic                w_accept;
    logic [PIPE_LAT-1:0] r_vld;

    // configuration-derived fit values
    logic signed [22:0] w_num;
    logic        [17:0] w_reach;
    logic        [35:0] r_scnum;
    logic        [17:0] r_reach;
    logic               r_num_pos;
    logic               r_sat;
    logic        [31:0] w_quo_c;
    logic        [30:0] w_rem_c;
    logic        [23:0] r_scale;
    logic        [31:0] r_seg1;
    logic        [31:0] r_seg2;
    logic        [33:0] r_ext;
    logic               w_cfg_zero;
    logic               w_nofit;

    // transaction pipeline
    logic signed [31:0] r_t;
    logic        [31:0] r_abs;
    logic               r_neg;
    logic               r_neg_d [DIV_LAT];
    logic        [31:0] w_quo_a;
    logic        [30:0] w_rem_a;
    logic        [30:0] r_w;
    logic        [30:0] r_w_d [W_DLY];
    logic        [31:0] w_phase;
    logic        [30:0] w_rem_b;
    logic signed [31:0] w_s;
    logic signed [31:0] w_c;
    logic signed [48:0] r_ps;
    logic signed [48:0] r_pc;
    logic signed [16:0] r_ra;
    logic signed [16:0] r_ca;
    logic signed [16:0] r_ra_d [ANG_DLY];
    logic signed [16:0] r_ca_d [ANG_DLY];
    logic        [15:0] r_x   [2];
    logic        [42:0] r_um  [2];
    logic        [31:0] r_hi  [2];
    logic        [31:0] r_ph  [2];
    logic signed [31:0] w_ls  [2];
    logic signed [31:0] w_lc  [2];
    logic signed [32:0] w_seg1s;
    logic signed [32:0] w_seg2s;
    logic signed [63:0] r_pex;
    logic signed [63:0] r_pey;
    logic signed [63:0] r_ptx;
    logic signed [63:0] r_pty;
    logic signed [39:0] r_ex;
    logic signed [39:0] r_ey;
    logic signed [39:0] r_tx;
    logic signed [39:0] r_ty;
    logic signed [41:0] w_ext;
    logic               w_fit;

    // output registers
    logic               r_done;
    logic               r_valid_res;
    logic        [30:0] r_wrapped;
    logic signed [16:0] r_out_ra;
    logic signed [16:0] r_out_ca;
    logic        [23:0] r_out_scale;
    logic signed [16:0] r_pvx;
    logic signed [16:0] r_pvy;
    logic signed [16:0] r_ebx;
    logic signed [16:0] r_eby;
    logic signed [16:0] r_tpx;
    logic signed [16:0] r_tpy;

    // angle reduced into one turn, input spans about plus or minus 2.85 turns
    function automatic logic [15:0] wrap_turn(input logic signed [17:0] a);
        logic signed [19:0] x;
        x = a[17] ? 20'(a) + 20'(3 * TURN_UNITS) : 20'(a);
        priority if (x >= 20'(5 * TURN_UNITS)) begin
            return 16'(x - 20'(5 * TURN_UNITS));
        end else if (x >= 20'(4 * TURN_UNITS)) begin
            return 16'(x - 20'(4 * TURN_UNITS));
        end else if (x >= 20'(3 * TURN_UNITS)) begin
            return 16'(x - 20'(3 * TURN_UNITS));
        end else if (x >= 20'(2 * TURN_UNITS)) begin
            return 16'(x - 20'(2 * TURN_UNITS));
        end else if (x >= 20'(TURN_UNITS)) begin
            return 16'(x - 20'(TURN_UNITS));
        end else begin
            return 16'(x);
        end
    endfunction

    function automatic logic fits(input logic signed [39:0] a,
                                  input logic signed [41:0] ext,
                                  input logic signed [41:0] hi);
        return ((42'(a) - ext) >= LO_BOUND) && ((42'(a) + ext) <= hi);
    endfunction

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= 31'd4000000;
            r_len1   <= 16'd25600;
            r_len2   <= 16'd19200;
            r_rad    <= 16'd2560;
            r_stroke <= 16'd768;
            r_rswing <= 17'sd3840;
            r_cswing <= 17'sd5760;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PERIOD:      r_period <= i_cfg_data;
                CFG_LEN1:        r_len1   <= i_cfg_data[15:0];
                CFG_LEN2:        r_len2   <= i_cfg_data[15:0];
                CFG_RADIUS:      r_rad    <= i_cfg_data[15:0];
                CFG_STROKE:      r_stroke <= i_cfg_data[15:0];
                CFG_ROOT_SWING:  r_rswing <= $signed(i_cfg_data[16:0]);
                CFG_CHILD_SWING: r_cswing <= $signed(i_cfg_data[16:0]);
                default: ;
            endcase
        end
    end

    // handshake and valid bits
    assign w_accept = start && !r_busy;
    assign busy     = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_vld  <= '0;
        end else begin
            r_busy <= 1'b0;
            r_vld  <= {r_vld[PIPE_LAT-2:0], w_accept};
        end
    end

    // fit scale from the configuration
    assign w_num   = NUM_BASE - 23'(r_stroke);
    assign w_reach = 18'(r_len1) + 18'(r_len2) + 18'(r_rad);

    always_ff @(posedge i_clk) begin
        r_scnum   <= {w_num[20:0], 15'd0} + 36'(w_reach >> 1);
        r_reach   <= w_reach;
        r_num_pos <= w_num > 23'sd0;
        r_sat     <= {6'd0, r_scnum} >= {r_reach, 24'd0};
        r_scale   <= r_sat ? 24'hFFFFFF : w_quo_c[23:0];
        r_seg1    <= 32'((40'(r_scale) * 40'(r_len1) + 40'd128) >> 8);
        r_seg2    <= 32'((40'(r_scale) * 40'(r_len2) + 40'd128) >> 8);
        r_ext     <= 34'((40'(r_scale) * 40'(r_rad) + 40'd128) >> 8)
                   + 34'({r_stroke, 7'd0}) + 34'd131072;
    end

    tlapf_div u_div_scale (
        .i_clk  (i_clk),
        .i_rem0 ({27'd0, r_scnum[35:32]}),
        .i_low  (r_scnum[31:0]),
        .i_den  ({13'd0, r_reach}),
        .o_quo  (w_quo_c),
        .o_rem  (w_rem_c)
    );

    assign w_cfg_zero = (r_period == '0) || (r_len1 == '0) || (r_len2 == '0)
                     || (r_rad == '0) || (r_stroke == '0) || view_small;
    assign w_nofit    = !r_num_pos || (r_scale == '0);

    // time wrap: magnitude modulo period, then fold negative times
    always_ff @(posedge i_clk) begin
        r_t   <= i_time_us;
        r_abs <= r_t[31] ? unsigned'(32'd0 - unsigned'(r_t)) : unsigned'(r_t);
        r_neg <= r_t[31];
        r_neg_d[0] <= r_neg;
        for (int k = 1; k < DIV_LAT; k++) begin
            r_neg_d[k] <= r_neg_d[k-1];
        end
        r_w <= (r_neg_d[DIV_LAT-1] && (w_rem_a != '0)) ? r_period - w_rem_a : w_rem_a;
        r_w_d[0] <= r_w;
        for (int k = 1; k < W_DLY; k++) begin
            r_w_d[k] <= r_w_d[k-1];
        end
    end

    tlapf_div u_div_wrap (
        .i_clk  (i_clk),
        .i_rem0 (31'd0),
        .i_low  (r_abs),
        .i_den  (r_period),
        .o_quo  (w_quo_a),
        .o_rem  (w_rem_a)
    );

    // phase as a 32-bit fraction of a turn
    tlapf_div u_div_phase (
        .i_clk  (i_clk),
        .i_rem0 (r_w),
        .i_low  (32'd0),
        .i_den  (r_period),
        .o_quo  (w_phase),
        .o_rem  (w_rem_b)
    );

    tlapf_sincos u_sc_swing (
        .i_clk   (i_clk),
        .i_phase (w_phase),
        .o_sin   (w_s),
        .o_cos   (w_c)
    );

    // swing angles and their phases
    always_ff @(posedge i_clk) begin
        r_ps <= 49'(r_rswing) * 49'(w_s);
        r_pc <= 49'(r_cswing) * 49'(w_c);
        r_ra <= clamp17(rnd_shift(64'(r_ps), 30));
        r_ca <= clamp17(rnd_shift(64'(r_pc), 30));
        r_ra_d[0] <= r_ra;
        r_ca_d[0] <= r_ca;
        for (int k = 1; k < ANG_DLY; k++) begin
            r_ra_d[k] <= r_ra_d[k-1];
            r_ca_d[k] <= r_ca_d[k-1];
        end
        r_x[0] <= wrap_turn(18'(r_ra));
        r_x[1] <= wrap_turn(18'(r_ra) + 18'(r_ca));
        for (int l = 0; l < 2; l++) begin
            // divide by 45 through a reciprocal, exact for this operand range
            r_um[l] <= 43'(22'(PH_ADJ) * 22'(r_x[l]) + 22'(PH_BIAS)) * 43'(RECIP_45);
            r_hi[l] <= 32'(r_x[l]) * 32'(PH_MUL);
            r_ph[l] <= r_hi[l] + 32'(r_um[l] >> RECIP_SH);
        end
    end

    tlapf_sincos u_sc_elbow (
        .i_clk   (i_clk),
        .i_phase (r_ph[0]),
        .o_sin   (w_ls[0]),
        .o_cos   (w_lc[0])
    );

    tlapf_sincos u_sc_tip (
        .i_clk   (i_clk),
        .i_phase (r_ph[1]),
        .o_sin   (w_ls[1]),
        .o_cos   (w_lc[1])
    );

    // link offsets and anchor points in 2^-16 pixel
    assign w_seg1s = $signed({1'b0, r_seg1});
    assign w_seg2s = $signed({1'b0, r_seg2});

    always_ff @(posedge i_clk) begin
        r_pex <= 64'(w_seg1s) * 64'(w_lc[0]);
        r_pey <= 64'(w_seg1s) * 64'(w_ls[0]);
        r_ptx <= 64'(w_seg2s) * 64'(w_lc[1]);
        r_pty <= 64'(w_seg2s) * 64'(w_ls[1]);
        r_ex  <= PX + 40'(rnd_shift(r_pex, 30));
        r_ey  <= PY + 40'(rnd_shift(r_pey, 30));
        r_tx  <= PX + 40'(rnd_shift(r_pex, 30)) + 40'(rnd_shift(r_ptx, 30));
        r_ty  <= PY + 40'(rnd_shift(r_pey, 30)) + 40'(rnd_shift(r_pty, 30));
    end

    assign w_ext = $signed({8'd0, r_ext});
    assign w_fit = fits(PX, w_ext, X_HI) && fits(PY, w_ext, Y_HI)
                && fits(r_ex, w_ext, X_HI) && fits(r_ey, w_ext, Y_HI)
                && fits(r_tx, w_ext, X_HI) && fits(r_ty, w_ext, Y_HI);

    // output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_vld[PIPE_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cfg_zero) begin
            r_wrapped <= '0;
            r_out_ra  <= '0;
            r_out_ca  <= '0;
        end else begin
            r_wrapped <= r_w_d[W_DLY-1];
            r_out_ra  <= r_ra_d[ANG_DLY-1];
            r_out_ca  <= r_ca_d[ANG_DLY-1];
        end
        if (w_cfg_zero || w_nofit) begin
            r_valid_res <= 1'b0;
            r_out_scale <= '0;
            r_pvx       <= '0;
            r_pvy       <= '0;
            r_ebx       <= '0;
            r_eby       <= '0;
            r_tpx       <= '0;
            r_tpy       <= '0;
        end else begin
            r_valid_res <= w_fit;
            r_out_scale <= r_scale;
            r_pvx       <= clamp17(rnd_shift(64'(PX), 12));
            r_pvy       <= clamp17(rnd_shift(64'(PY), 12));
            r_ebx       <= clamp17(rnd_shift(64'(r_ex), 12));
            r_eby       <= clamp17(rnd_shift(64'(r_ey), 12));
            r_tpx       <= clamp17(rnd_shift(64'(r_tx), 12));
            r_tpy       <= clamp17(rnd_shift(64'(r_ty), 12));
        end
    end

    assign o_done         = r_done;
    assign o_valid_res    = r_valid_res;
    assign o_wrapped_time = r_wrapped;
    assign o_root_angle   = r_out_ra;
    assign o_child_angle  = r_out_ca;
    assign o_fit_scale    = r_out_scale;
    assign o_pivot_x      = r_pvx;
    assign o_pivot_y      = r_pvy;
    assign o_elbow_x      = r_ebx;
    assign o_elbow_y      = r_eby;
    assign o_tip_x        = r_tpx;
    assign o_tip_y        = r_tpy;

    // every started transaction comes out after the fixed latency
    `ASSERT_DELAYED(a_latency, i_clk, i_rst_n, w_accept, PIPE_LAT + 1, o_done)
    // wrapped time always lands below the period
    `ASSERT_IMPLIES(a_wrap_range, i_clk, i_rst_n, o_done && (r_period != '0), o_wrapped_time < r_period)
    // a zero register blanks the whole result
    `ASSERT_IMPLIES(a_zero_cfg, i_clk, i_rst_n, o_done && w_cfg_zero, !o_valid_res && (o_wrapped_time == '0) && (o_fit_scale == '0))

endmodule

`default_nettype wire

[verif/two_link_arm_pose_fit_tb.sv]
// testbench for two_link_arm_pose_fit: directed and random time stamps under several settings
// depends on tlapf_pkg and the two_link_arm_pose_fit design; self-checking through a scoreboard class
`timescale 1ns / 100ps

module two_link_arm_pose_fit_tb;
    import tlapf_pkg::*;

    typedef struct {
        bit                valid_res;
        bit [30:0]         wrapped_time;
        bit signed [16:0]  root_angle;
        bit signed [16:0]  child_angle;
        bit [23:0]         fit_scale;
        bit signed [16:0]  pivot_x;
        bit signed [16:0]  pivot_y;
        bit signed [16:0]  elbow_x;
        bit signed [16:0]  elbow_y;
        bit signed [16:0]  tip_x;
        bit signed [16:0]  tip_y;
    } t_pose;

    class t_pose_scoreboard;
        bit [30:0]        period;
        bit [15:0]        len1, len2, radius, stroke;
        bit signed [16:0] root_swing, child_swing;
        t_pose            pending_poses[$];
        int               n_errors;
        int               n_checked;
        int               n_valid;

        function new();
            period = 31'd4000000;
            len1 = 16'd25600;
            len2 = 16'd19200;
            radius = 16'd2560;
            stroke = 16'd768;
            root_swing = 17'sd3840;
            child_swing = 17'sd5760;
        endfunction

        function void write_reg(t_cfg_idx idx, bit [30:0] data);
            case (idx)
                CFG_PERIOD:      period = data;
                CFG_LEN1:        len1 = data[15:0];
                CFG_LEN2:        len2 = data[15:0];
                CFG_RADIUS:      radius = data[15:0];
                CFG_STROKE:      stroke = data[15:0];
                CFG_ROOT_SWING:  root_swing = data[16:0];
                CFG_CHILD_SWING: child_swing = data[16:0];
                default: ;
            endcase
        endfunction

        // round half away from zero, then drop s bits
        function longint round_drop(longint v, int s);
            bit [63:0] h;
            bit [63:0] m;
            h = 64'd1 << (s - 1);
            if (v >= 0) begin
                m = (64'(v) + h) >> s;
                return longint'(m);
            end
            m = ((64'd0 - 64'(v)) + h) >> s;
            return -longint'(m);
        endfunction

        function longint sat17(longint v);
            if (v > 65535) return 65535;
            if (v < -65536) return -65536;
            return v;
        endfunction

        function bit [63:0] quarter_wave(bit [63:0] u);
            bit [63:0] u2;
            bit [63:0] p;
            u2 = (u * u) >> 30;
            p = 64'd172272;
            p = 64'd5026995 - ((u2 * p) >> 30);
            p = 64'd85569310 - ((u2 * p) >> 30);
            p = 64'd693598668 - ((u2 * p) >> 30);
            p = 64'd1686629713 - ((u2 * p) >> 30);
            p = (u * p) >> 30;
            if (p > 64'd1073741824) p = 64'd1073741824;
            return p;
        endfunction

        function void turn_sin_cos(bit [31:0] ph, output longint s, output longint c);
            longint a, b;
            a = longint'(quarter_wave({34'd0, ph[29:0]}));
            b = longint'(quarter_wave(64'd1073741824 - {34'd0, ph[29:0]}));
            case (ph[31:30])
                2'd0: begin s = a; c = b; end
                2'd1: begin s = b; c = -a; end
                2'd2: begin s = -a; c = -b; end
                default: begin s = -b; c = a; end
            endcase
        endfunction

        function bit [31:0] degree_phase(longint a);
            bit [63:0] ph;
            a = a % 46080;
            if (a < 0) a += 46080;
            ph = ((64'(a) << 32) + 64'd23040) / 64'd46080;
            return ph[31:0];
        endfunction

        function bit fits_side(longint a, longint ext, longint side);
            return !(a - ext < -SLACK || a + ext > side * 65536 + SLACK);
        endfunction

        function t_pose predict_pose(bit signed [31:0] t_us);
            t_pose     r;
            longint    p, w, s, c, ra, ca, num, reach, px, py;
            longint    sr, cr, st, ct, seg1, seg2, ex, ey, tx, ty, ext;
            bit [63:0] ph, scale;
            r = '{default: 0};
            if (period == 0 || len1 == 0 || len2 == 0 || radius == 0 || stroke == 0)
                return r;
            p = longint'(period);
            w = longint'(t_us) % p;
            if (w < 0) w += p;
            r.wrapped_time = w[30:0];
            ph = (64'(w) << 32) / 64'(p);
            turn_sin_cos(ph[31:0], s, c);
            ra = sat17(round_drop(longint'(root_swing) * s, 30));
            ca = sat17(round_drop(longint'(child_swing) * c, 30));
            r.root_angle = ra[16:0];
            r.child_angle = ca[16:0];
            num = longint'(VIEW_MIN) * 256 - longint'(stroke) - 1024;
            if (num <= 0) return r;
            reach = longint'(len1) + longint'(len2) + longint'(radius);
            scale = (64'(num) * 32768 + 64'(reach / 2)) / 64'(reach);
            if (scale > 64'hFFFFFF) scale = 64'hFFFFFF;
            if (scale == 0) return r;
            r.fit_scale = scale[23:0];
            px = longint'(VIEW_WIDTH) * 32768;
            py = longint'(VIEW_HEIGHT) * 32768;
            turn_sin_cos(degree_phase(ra), sr, cr);
            turn_sin_cos(degree_phase(ra + ca), st, ct);
            seg1 = longint'((scale * len1 + 128) >> 8);
            seg2 = longint'((scale * len2 + 128) >> 8);
            ex = px + round_drop(seg1 * cr, 30);
            ey = py + round_drop(seg1 * sr, 30);
            tx = ex + round_drop(seg2 * ct, 30);
            ty = ey + round_drop(seg2 * st, 30);
            ext = longint'((64'(radius) * scale + 128) >> 8) + longint'(stroke) * 128 + 131072;
            r.valid_res = fits_side(px, ext, VIEW_WIDTH) && fits_side(py, ext, VIEW_HEIGHT) &&
                          fits_side(ex, ext, VIEW_WIDTH) && fits_side(ey, ext, VIEW_HEIGHT) &&
                          fits_side(tx, ext, VIEW_WIDTH) && fits_side(ty, ext, VIEW_HEIGHT);
            r.pivot_x = 17'(sat17(round_drop(px, 12)));
            r.pivot_y = 17'(sat17(round_drop(py, 12)));
            r.elbow_x = 17'(sat17(round_drop(ex, 12)));
            r.elbow_y = 17'(sat17(round_drop(ey, 12)));
            r.tip_x = 17'(sat17(round_drop(tx, 12)));
            r.tip_y = 17'(sat17(round_drop(ty, 12)));
            return r;
        endfunction

        function void note_time(bit signed [31:0] t_us);
            pending_poses.push_back(predict_pose(t_us));
        endfunction

        function void check_pose(t_pose act);
            t_pose e;
            if (pending_poses.size() == 0) begin
                $error("result with no transaction outstanding");
                n_errors++;
                return;
            end
            e = pending_poses.pop_front();
            n_checked++;
            if (act.valid_res) n_valid++;
            if (act.valid_res !== e.valid_res) begin
                $error("valid_res: expected %0d, got %0d", e.valid_res, act.valid_res);
                n_errors++;
            end
            if (act.wrapped_time !== e.wrapped_time) begin
                $error("wrapped_time: expected %0d, got %0d", e.wrapped_time, act.wrapped_time);
                n_errors++;
            end
            if (act.root_angle !== e.root_angle) begin
                $error("root_angle: expected %0d, got %0d", e.root_angle, act.root_angle);
                n_errors++;
            end
            if (act.child_angle !== e.child_angle) begin
                $error("child_angle: expected %0d, got %0d", e.child_angle, act.child_angle);
                n_errors++;
            end
            if (act.fit_scale !== e.fit_scale) begin
                $error("fit_scale: expected %0d, got %0d", e.fit_scale, act.fit_scale);
                n_errors++;
            end
            if (act.pivot_x !== e.pivot_x) begin
                $error("pivot_x: expected %0d, got %0d", e.pivot_x, act.pivot_x);
                n_errors++;
            end
            if (act.pivot_y !== e.pivot_y) begin
                $error("pivot_y: expected %0d, got %0d", e.pivot_y, act.pivot_y);
                n_errors++;
            end
            if (act.elbow_x !== e.elbow_x) begin
                $error("elbow_x: expected %0d, got %0d", e.elbow_x, act.elbow_x);
                n_errors++;
            end
            if (act.elbow_y !== e.elbow_y) begin
                $error("elbow_y: expected %0d, got %0d", e.elbow_y, act.elbow_y);
                n_errors++;
            end
            if (act.tip_x !== e.tip_x) begin
                $error("tip_x: expected %0d, got %0d", e.tip_x, act.tip_x);
                n_errors++;
            end
            if (act.tip_y !== e.tip_y) begin
                $error("tip_y: expected %0d, got %0d", e.tip_y, act.tip_y);
                n_errors++;
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic signed [31:0]  i_time_us = '0;
    logic                i_cfg_we = 1'b0;
    logic        [2:0]   i_cfg_idx = '0;
    logic        [30:0]  i_cfg_data = '0;
    logic                o_done;
    logic                o_valid_res;
    logic        [30:0]  o_wrapped_time;
    logic signed [16:0]  o_root_angle, o_child_angle;
    logic        [23:0]  o_fit_scale;
    logic signed [16:0]  o_pivot_x, o_pivot_y, o_elbow_x, o_elbow_y, o_tip_x, o_tip_y;

    t_pose_scoreboard sb = new();
    int               idle_pct;
    int               n_sent;

    always #2 i_clk = ~i_clk;

    two_link_arm_pose_fit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_time_us(i_time_us), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .o_done(o_done), .o_valid_res(o_valid_res),
        .o_wrapped_time(o_wrapped_time), .o_root_angle(o_root_angle),
        .o_child_angle(o_child_angle), .o_fit_scale(o_fit_scale),
        .o_pivot_x(o_pivot_x), .o_pivot_y(o_pivot_y), .o_elbow_x(o_elbow_x),
        .o_elbow_y(o_elbow_y), .o_tip_x(o_tip_x), .o_tip_y(o_tip_y)
    );

    // transaction and result monitor, sees pre-edge values
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) sb.note_time(i_time_us);
            if (o_done) sb.check_pose('{o_valid_res, o_wrapped_time, o_root_angle,
                                        o_child_angle, o_fit_scale, o_pivot_x, o_pivot_y,
                                        o_elbow_x, o_elbow_y, o_tip_x, o_tip_y});
        end
    end

    task automatic send_time(bit signed [31:0] t_us);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_time_us <= t_us;
        do @(posedge i_clk); while (!(start && !busy));
        n_sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_poses.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, bit [30:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        sb.write_reg(idx, data);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_all(bit [30:0] per, bit [15:0] l1, bit [15:0] l2, bit [15:0] rad,
                             bit [15:0] stk, bit signed [16:0] rsw, bit signed [16:0] csw);
        write_reg(CFG_PERIOD, per);
        write_reg(CFG_LEN1, {15'd0, l1});
        write_reg(CFG_LEN2, {15'd0, l2});
        write_reg(CFG_RADIUS, {15'd0, rad});
        write_reg(CFG_STROKE, {15'd0, stk});
        write_reg(CFG_ROOT_SWING, {14'd0, rsw});
        write_reg(CFG_CHILD_SWING, {14'd0, csw});
        repeat (40) @(posedge i_clk);
    endtask

    task automatic random_burst(int n);
        bit signed [31:0] t;
        bit [30:0]        p;
        repeat (n) begin
            p = (sb.period == 0) ? 31'd1 : sb.period;
            case ($urandom_range(3))
                0: t = $urandom();
                1: t = $signed($urandom_range(p - 1, 0));
                2: t = -$signed($urandom_range(p - 1, 0));
                default: t = $signed(32'($urandom_range(8, 0)) * p) + $signed($urandom_range(2, 0)) - 1;
            endcase
            send_time(t);
        end
        drain();
    endtask

    initial begin
        int ph;
        bit signed [31:0] edges[$];
        edges = '{0, 1, -1, 32'sh7FFFFFFF, 32'sh80000000,
                  1000000, 2000000, 3000000, 3999999, 4000000,
                  -4000000, -1000000, 32'sh55555555, 32'shAAAAAAAA};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_pct = 0;
        foreach (edges[k]) send_time(edges[k]);
        drain();
        // zero settings, one register at a time
        write_reg(CFG_PERIOD, 31'd0);
        send_time(12345); send_time(-7);
        drain();
        write_all(31'd4000000, 16'd0, 16'd19200, 16'd2560, 16'd768, 17'sd3840, 17'sd5760);
        send_time(5);
        drain();
        write_all(31'd4000000, 16'd25600, 16'd0, 16'd2560, 16'd768, 17'sd3840, 17'sd5760);
        send_time(5);
        drain();
        write_all(31'd4000000, 16'd25600, 16'd19200, 16'd0, 16'd768, 17'sd3840, 17'sd5760);
        send_time(5);
        drain();
        write_all(31'd4000000, 16'd25600, 16'd19200, 16'd2560, 16'd0, 17'sd3840, 17'sd5760);
        send_time(5);
        drain();

        for (ph = 0; ph < 8; ph++) begin
            idle_pct = (ph % 4 == 1) ? 49 : (ph % 4 == 3) ? 26 : 0;
            case (ph)
                0: write_all(31'd4000000, 16'd25600, 16'd19200, 16'd2560, 16'd768,
                             17'sd3840, 17'sd5760);
                // tiny links: scale saturates
                1: write_all(31'd1, 16'd1, 16'd1, 16'd1, 16'd1, 17'sd46080, -17'sd46080);
                2: write_all(31'h7FFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                             -17'sd46080, 17'sd46080);
                3: write_all(31'd7, 16'd1, 16'd1, 16'd1, 16'd65535, 17'sh10000, 17'sd65535);
                default: write_all(31'($urandom_range(31'h7FFFFFFF, 1)),
                                   16'($urandom_range(65535, 1)),
                                   16'($urandom_range(65535, 1)),
                                   16'($urandom_range(65535, 1)),
                                   16'($urandom_range(65535, 1)),
                                   17'($urandom()), 17'($urandom()));
            endcase
            random_burst(130);
        end

        $display("sent %0d time stamps, checked %0d poses (%0d in view)",
                 n_sent, sb.n_checked, sb.n_valid);
        $display("settings: reset, zero registers, saturating scale, extreme swings, random");
        if (sb.n_errors == 0 && sb.pending_poses.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
